// File: src/energy_loss_range_stepper_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range stepper
// Small wrappers for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ENERGY_LOSS_RANGE_STEPPER_TOP_ASSERT_SVH
`define ENERGY_LOSS_RANGE_STEPPER_TOP_ASSERT_SVH
`define ELRS_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define ELRS_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`endif

// File: src/elrs_pkg.sv
// ----------------------------------------------------------------------------
// elrs_pkg
// Shared types and constants for the range stepper.
// ----------------------------------------------------------------------------
package elrs_pkg;
  localparam int TABLE_POINTS = 64;
  localparam int IDX_W = $clog2(TABLE_POINTS);
  localparam int CNT_W = $clog2(TABLE_POINTS + 1);
  localparam logic [39:0] RANGE_MAX = 40'hFF_FFFF_FFFF;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STEP   = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_LOSS, S_SEGB, S_SCAN, S_SCANW, S_SEG, S_SEGW, S_MUL, S_DIV,
    S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic loss;
    logic apply;
    logic scan_init;
    logic scan_rd;
    logic scan_eval;
    logic seg_rd;
    logic seg_eval;
    logic mul;
    logic div_step;
    logic fin;
    logic out_set;
  } cmd_t;

  typedef struct packed {
    logic stop_now;
    logic scan_last;
    logic no_interp;
    logic div_done;
    logic out_busy;
  } sts_t;
endpackage

// File: src/energy_loss_range_stepper_top.sv
// ----------------------------------------------------------------------------
// energy_loss_range_stepper_top
// Steps a particle through a loaded stopping power table.
// ----------------------------------------------------------------------------
// A load beat is written to the table from the idle state. A start beat scans
// every loaded entry, a read state and an evaluate state per entry through the
// single memory read port (one pass with an empty table), reads the segment
// (S_SEG, S_SEGW, S_SEGB), then multiplies and runs a 64-step restoring divider.
// Without interpolation (empty or one-entry table, exact hit, flat segment)
// the divider is skipped. A step beat first applies the loss; a step that stops
// the particle skips the scan and goes straight to the output. The result is
// held in an output register; while it waits the next beat is still accepted
// and then waits in its last state until the register frees.
`include "energy_loss_range_stepper_top_assert.svh"
module energy_loss_range_stepper_top import elrs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_index[5:0], point_energy[37:6], point_stopping_power[69:38],
  // start_energy[101:70], zero [103:102]
  input  logic [103:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // travelled_range[39:0], energy[71:40], stopping_power[103:72]
  output logic [103:0] m_tdata,
  // stopped
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);
  logic [31:0] step_length;
  logic busy;
  cmd_t cmd;
  sts_t sts;
  logic [39:0] o_range;
  logic [31:0] o_energy, o_power;

  always_ff @(posedge clk) begin
    if (rst) step_length <= 32'd65536;
    else if (cfg_we) step_length <= cfg_wdata;
  end

  assign s_tready = !busy && !rst;

  elrs_ctrl u_ctrl (
    .clk, .rst, .in_fire(s_tvalid && s_tready), .op(s_tuser),
    .sts, .busy, .cmd
  );

  elrs_dp u_dp (
    .clk, .rst, .cmd,
    .point_index(s_tdata[5:0]), .point_energy(s_tdata[37:6]),
    .point_stopping_power(s_tdata[69:38]), .start_energy(s_tdata[101:70]),
    .step_length, .out_ready(m_tready), .sts, .out_valid(m_tvalid),
    .out_range(o_range), .out_energy(o_energy), .out_power(o_power)
  );

  assign m_tdata = {o_power, o_energy, o_range};
  assign m_tuser = (o_energy == 32'd0);

  `ELRS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ELRS_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0({cmd.load, cmd.out_set, cmd.div_step}))
  `ELRS_ASSERT_IMPL(a_busy_noacc, busy, !s_tready)
endmodule

// File: src/elrs_ctrl.sv
// ----------------------------------------------------------------------------
// elrs_ctrl
// Sequencer for load, start and step items.
// ----------------------------------------------------------------------------
module elrs_ctrl import elrs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [1:0] op,
  input  sts_t       sts,
  output logic       busy,
  output cmd_t       cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (op)
            OP_LOAD: cmd.load = 1'b1;
            OP_START: begin
              cmd.start = 1'b1;
              cmd.scan_init = 1'b1;
              state_next = S_SCAN;
            end
            OP_STEP: begin
              cmd.loss = 1'b1;
              state_next = S_LOSS;
            end
            default: ;
          endcase
        end
      end
      S_LOSS: begin
        cmd.apply = 1'b1;
        if (sts.stop_now) state_next = S_OUT;
        else begin
          cmd.scan_init = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        state_next = S_SCANW;
      end
      S_SCANW: begin
        cmd.scan_eval = 1'b1;
        state_next = sts.scan_last ? S_SEG : S_SCAN;
      end
      S_SEG: begin
        cmd.seg_rd = 1'b1;
        state_next = S_SEGW;
      end
      S_SEGW: begin
        cmd.seg_eval = 1'b1;
        state_next = S_SEGB;
      end
      S_SEGB: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        if (sts.no_interp) state_next = S_FIN;
        else begin
          cmd.mul = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_FIN;
        else cmd.div_step = 1'b1;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_set = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: src/elrs_dp.sv
// ----------------------------------------------------------------------------
// elrs_dp
// Table memory, range and energy registers, interpolation datapath.
// ----------------------------------------------------------------------------
module elrs_dp import elrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [5:0]  point_index,
  input  logic [31:0] point_energy,
  input  logic [31:0] point_stopping_power,
  input  logic [31:0] start_energy,
  input  logic [31:0] step_length,
  input  logic        out_ready,
  output sts_t        sts,
  output logic        out_valid,
  output logic [39:0] out_range,
  output logic [31:0] out_energy,
  output logic [31:0] out_power
);
  logic [63:0] tbl [TABLE_POINTS];
  logic [63:0] rd;
  logic [IDX_W-1:0] raddr;
  logic [CNT_W-1:0] n;
  logic [39:0] range_acc;
  logic [31:0] en, pw;
  logic [63:0] loss;
  logic [CNT_W-1:0] si;
  logic        found_eq;
  logic [31:0] eq_pw;
  logic [31:0] eq_pw0;
  logic        have_below;
  logic [IDX_W-1:0] below;
  logic [31:0] ea, pa;
  logic        seg_flat;
  logic        no_interp;
  logic        neg;
  logic [31:0] mx, my, md;
  logic [32:0] dx, dy, dd;
  logic [63:0] rem;
  logic [63:0] rem_sh;
  logic [63:0] quo;
  logic [6:0]  dcnt;
  logic [IDX_W-1:0] seg_a;
  logic        seg_hi;
  logic        seg_eval_d;

  always_ff @(posedge clk) begin
    if (cmd.load && ({1'b0, point_index} < 7'(TABLE_POINTS)))
      tbl[point_index[IDX_W-1:0]] <= {point_energy, point_stopping_power};
    rd <= tbl[raddr];
  end

  always_comb begin
    raddr = si[IDX_W-1:0];
    if (cmd.seg_rd) raddr = seg_a;
    if (seg_hi) raddr = seg_a + IDX_W'(1);
  end

  always_comb begin
    if (!have_below) seg_a = '0;
    else if ({1'b0, below} == n - CNT_W'(1)) seg_a = IDX_W'(n - CNT_W'(2));
    else seg_a = below;
  end

  assign sts.stop_now = (loss >= {32'd0, en});
  assign sts.scan_last = (si == n - CNT_W'(1)) || (n == '0);
  assign sts.no_interp = no_interp;
  assign sts.div_done = (dcnt == 7'd0);
  assign sts.out_busy = out_valid && !out_ready;

  // point b is on rd in the cycle after seg_eval
  assign dx = {1'b0, en} - {1'b0, ea};
  assign dy = {1'b0, rd[31:0]} - {1'b0, pa};
  assign dd = {1'b0, rd[63:32]} - {1'b0, ea};
  assign rem_sh = {rem[62:0], quo[63]};
  assign no_interp = (n <= CNT_W'(1)) || found_eq || seg_flat;

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      range_acc <= '0;
      en <= '0;
      pw <= '0;
      out_valid <= 1'b0;
      seg_hi <= 1'b0;
      dcnt <= '0;
    end else begin
      if (cmd.load && ({1'b0, point_index} < 7'(TABLE_POINTS))
          && ({1'b0, point_index} >= n))
        n <= CNT_W'(point_index) + CNT_W'(1);
      if (cmd.start) begin
        range_acc <= '0;
        en <= start_energy;
      end
      if (cmd.loss) begin
        loss <= ({32'd0, pw} * {32'd0, step_length}) >> 20;
        if (range_acc > RANGE_MAX - 40'(step_length)) range_acc <= RANGE_MAX;
        else range_acc <= range_acc + 40'(step_length);
      end
      if (cmd.apply) begin
        if (sts.stop_now) begin
          en <= '0;
          pw <= '0;
        end else en <= en - loss[31:0];
      end
      if (cmd.scan_init) begin
        si <= '0;
        found_eq <= 1'b0;
        have_below <= 1'b0;
      end
      if (cmd.scan_eval) begin
        if (n != '0) begin
          if (!found_eq && rd[63:32] == en) begin
            found_eq <= 1'b1;
            eq_pw <= rd[31:0];
          end
          if (rd[63:32] < en) begin
            have_below <= 1'b1;
            below <= si[IDX_W-1:0];
          end
        end
        si <= si + CNT_W'(1);
      end
      if (cmd.seg_rd) seg_hi <= 1'b1;
      if (cmd.seg_eval) begin
        seg_hi <= 1'b0;
        ea <= rd[63:32];
        pa <= rd[31:0];
      end
      if (cmd.mul) begin
        quo <= 64'(mx) * 64'(my);
        rem <= '0;
        dcnt <= 7'd64;
      end
      if (cmd.div_step) begin
        if (rem_sh >= {32'd0, md}) begin
          rem <= rem_sh - {32'd0, md};
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
        dcnt <= dcnt - 7'd1;
      end
      if (cmd.fin) begin
        if (n == '0) pw <= '0;
        else if (n == CNT_W'(1) || found_eq) pw <= (n == CNT_W'(1)) ? eq_pw0 : eq_pw;
        else if (no_interp || quo == '0) pw <= pa;
        else if (neg) pw <= (quo >= {32'd0, pa}) ? 32'd0 : pa - quo[31:0];
        else pw <= (quo > {32'd0, ~pa}) ? 32'hFFFF_FFFF : pa + quo[31:0];
      end
      if (cmd.out_set) begin
        out_valid <= 1'b1;
        out_range <= range_acc;
        out_energy <= en;
        out_power <= pw;
      end else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_eval && si == '0) eq_pw0 <= rd[31:0];
    if (seg_eval_d) begin
      mx <= dx[32] ? 32'(-dx) : dx[31:0];
      my <= dy[32] ? 32'(-dy) : dy[31:0];
      md <= dd[32] ? 32'(-dd) : dd[31:0];
      neg <= (dx[32] ^ dy[32]) ^ dd[32];
      seg_flat <= (rd[63:32] == ea);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) seg_eval_d <= 1'b0;
    else seg_eval_d <= cmd.seg_eval;
  end
endmodule

// File: tb/elrs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elrs_checker
// Watches the input and output streams and the step length register of the
// range stepper, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module elrs_checker import elrs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [103:0] m_tdata,
  input  logic         m_tuser,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  output int           fail_count,
  output int           pending
);
  typedef struct packed {
    logic [39:0] trange;
    logic [31:0] energy;
    logic [31:0] power;
    logic        stopped;
  } track_t;

  logic [31:0] tbl_e [TABLE_POINTS];
  logic [31:0] tbl_p [TABLE_POINTS];
  int unsigned npoints;
  logic [31:0] step_len;
  logic [39:0] range_acc;
  logic [31:0] cur_energy;
  logic [31:0] cur_power;
  track_t      track_q[$];

  assign pending = track_q.size();

  function automatic logic [31:0] interp_power(logic [31:0] x);
    int below;
    int a;
    int b;
    logic signed [65:0] dx, dy, dd;
    logic [65:0] mx, my, md, q;
    logic neg;
    below = -1;
    if (npoints == 0) return '0;
    if (npoints == 1) return tbl_p[0];
    for (int i = 0; i < npoints; i++)
      if (tbl_e[i] == x) return tbl_p[i];
    for (int i = 0; i < npoints; i++)
      if (tbl_e[i] < x) below = i;
    if (below < 0) begin
      a = 0; b = 1;
    end else if (below == npoints - 1) begin
      a = npoints - 2; b = npoints - 1;
    end else begin
      a = below; b = below + 1;
    end
    if (tbl_e[a] == tbl_e[b]) return tbl_p[a];
    dx = $signed({34'd0, x}) - $signed({34'd0, tbl_e[a]});
    dy = $signed({34'd0, tbl_p[b]}) - $signed({34'd0, tbl_p[a]});
    dd = $signed({34'd0, tbl_e[b]}) - $signed({34'd0, tbl_e[a]});
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    md = dd < 0 ? -dd : dd;
    neg = ((dx < 0) != (dy < 0)) != (dd < 0);
    q = (mx * my) / md;
    if (q == 0) return tbl_p[a];
    if (neg) begin
      if (q >= {34'd0, tbl_p[a]}) return '0;
      return tbl_p[a] - q[31:0];
    end
    if (q > 66'hFFFF_FFFF - tbl_p[a]) return 32'hFFFF_FFFF;
    return tbl_p[a] + q[31:0];
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [1:0]  op;
    logic [63:0] loss;
    int          idx;
    track_t      got, want;
    if (rst) begin
      npoints = 0;
      step_len = 32'd65536;
      range_acc = 0;
      cur_energy = 0;
      cur_power = 0;
      fail_count = 0;
      track_q.delete();
    end else begin
      if (cfg_we) step_len = cfg_wdata;
      if (s_tvalid && s_tready) begin
        op = s_tuser;
        if (op == OP_LOAD) begin
          idx = int'(s_tdata[5:0]);
          tbl_e[idx] = s_tdata[37:6];
          tbl_p[idx] = s_tdata[69:38];
          if (idx + 1 > npoints) npoints = idx + 1;
        end else if (op == OP_START || op == OP_STEP) begin
          if (op == OP_START) begin
            range_acc = 0;
            cur_energy = s_tdata[101:70];
            cur_power = interp_power(cur_energy);
          end else begin
            loss = (64'(cur_power) * 64'(step_len)) >> 20;
            if (range_acc > RANGE_MAX - step_len) range_acc = RANGE_MAX;
            else range_acc = range_acc + step_len;
            if (loss >= cur_energy) begin
              cur_energy = 0;
              cur_power = 0;
            end else begin
              cur_energy = cur_energy - loss[31:0];
              cur_power = interp_power(cur_energy);
            end
          end
          track_q.push_back('{range_acc, cur_energy, cur_power, cur_energy == 0});
        end
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[39:0], m_tdata[71:40], m_tdata[103:72], m_tuser};
        if (track_q.size() == 0) begin
          report("unexpected beat", m_tdata[63:0], 64'd0);
        end else begin
          want = track_q.pop_front();
          if (got.trange !== want.trange)
            report("range", 64'(got.trange), 64'(want.trange));
          if (got.energy !== want.energy)
            report("energy", 64'(got.energy), 64'(want.energy));
          if (got.power !== want.power)
            report("power", 64'(got.power), 64'(want.power));
          if (got.stopped !== want.stopped)
            report("stopped", 64'(got.stopped), 64'(want.stopped));
        end
      end
    end
  end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives table loads, particle starts and steps into the range stepper over
// several step lengths, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench import elrs_pkg::*; ();
  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [103:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we = 0;
  logic [31:0]  cfg_wdata = '0;
  int           fail_count;
  int           pending;
  bit           no_gaps = 0;
  bit           hold_off = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  energy_loss_range_stepper_top uut (.*);
  elrs_checker chk (.*);

  initial begin
    #10ms;
    $display("energy_loss_range_stepper_top regression: fail");
    $finish;
  end

  // output side: random stall bursts, one long hold-off
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        m_tready <= 0;
        for (int i = 0; i < 3000; i++) @(negedge clk);
        hold_off = 0;
      end
      if (!no_gaps && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        n = $urandom_range(1, 11);
        repeat (n) @(negedge clk);
      end
      m_tready <= 1;
      @(negedge clk);
    end
  end

  task automatic send_beat(logic [1:0] op, logic [5:0] idx, logic [31:0] pe,
                           logic [31:0] pp, logic [31:0] se);
    if (!no_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {2'b00, se, pp, pe, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_step(logic [31:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // ascending table with random content, npts points
  task automatic load_table(int npts);
    logic [31:0] e;
    e = $urandom_range(0, 32'h0400_0000);
    for (int i = 0; i < npts; i++) begin
      send_beat(OP_LOAD, 6'(i), e, $urandom, '0);
      e = e + $urandom_range(1, 32'h0380_0000);
    end
  endtask

  initial begin
    logic [31:0] steps [5];
    int npts;
    steps = '{32'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0040_0000, 32'h0000_0400};
    repeat (6) @(negedge clk);
    rst = 0;
    @(negedge clk);
    // no table yet, step before start, ignored operation
    send_beat(OP_START, '0, '0, '0, 32'h0100_0000);
    send_beat(OP_STEP, '0, '0, '0, '0);
    send_beat(OP_IGNORE, '0, '0, '0, '0);
    send_beat(OP_LOAD, 6'd0, 32'h0010_0000, 32'h0100_0000, '0);
    send_beat(OP_START, '0, '0, '0, 32'h0001_0000);
    send_beat(OP_LOAD, 6'd1, 32'h0020_0000, 32'h0080_0000, '0);
    send_beat(OP_LOAD, 6'd2, 32'h0020_0000, 32'h0300_0000, '0);
    send_beat(OP_LOAD, 6'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_beat(OP_START, '0, '0, '0, 32'h0010_0000);
    send_beat(OP_START, '0, '0, '0, 32'h0000_0000);
    send_beat(OP_START, '0, '0, '0, 32'h0020_0000);
    send_beat(OP_START, '0, '0, '0, 32'h0018_0000);
    send_beat(OP_START, '0, '0, '0, 32'hFFFF_FFFF);
    send_beat(OP_STEP, '0, '0, '0, '0);
    send_beat(OP_START, '0, '0, '0, 32'hFFFF_FFFE);
    send_beat(OP_STEP, '0, '0, '0, '0);
    send_beat(OP_LOAD, 6'd4, 32'hFFFF_FFFF, 32'h0000_0000, '0);
    hold_off = 1;
    for (int i = 0; i < 20; i++) send_beat(OP_STEP, '0, '0, '0, '0);
    set_step(32'hFFFF_FFFF);
    // a run of steps at the maximum step length
    for (int i = 0; i < 6; i++) send_beat(OP_STEP, '0, '0, '0, '0);
    for (int ph = 0; ph < 5; ph++) begin
      set_step(steps[ph]);
      drain();
      npts = (ph == 2) ? 64 : int'($urandom_range(2, 8));
      load_table(npts);
      if (ph == 4) no_gaps = 1;
      for (int k = 0; k < 14; k++) begin
        case ($urandom_range(0, 9))
          0: send_beat(OP_LOAD, 6'($urandom_range(0, npts - 1)), $urandom, $urandom,
                       $urandom);
          1: send_beat(OP_IGNORE, 6'($urandom), $urandom, $urandom, $urandom);
          2, 3: send_beat(OP_START, 6'($urandom), $urandom, $urandom, $urandom);
          default: send_beat(OP_START, '0, '0, '0, $urandom_range(0, 32'h2000_0000));
        endcase
        repeat ($urandom_range(1, 5))
          send_beat(OP_STEP, 6'($urandom), $urandom, $urandom, '0);
      end
    end
    drain();
    if (fail_count == 0) begin
      $display("energy_loss_range_stepper_top regression: pass");
    end else begin
      $display("energy_loss_range_stepper_top regression: fail");
    end
    $finish;
  end
endmodule
